[src/byte_stuffing_deframer_fifo_assert.svh]
// Assertion helpers for the deframer block.
`ifndef BYTE_STUFFING_DEFRAMER_FIFO_ASSERT_SVH
`define BYTE_STUFFING_DEFRAMER_FIFO_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/bsd_pkg.sv]
`timescale 1ns / 1ps

package bsd_pkg;

   // Default buffer depth in bytes
   localparam int DefaultFifoDepth = 1024;

   // Field widths
   localparam int ByteW    = 8;
   localparam int FillW    = 11;
   localparam int FramesW  = 16;
   localparam int ActionW  = 2;
   localparam int CsrAddrW = 1;

   // Register reset values: 'A' and 'Z'
   localparam logic [ByteW-1:0] EscapeCharReset = 8'd65;
   localparam logic [ByteW-1:0] EndCharReset    = 8'd90;

   // Register indexes
   localparam logic [CsrAddrW-1:0] CsrEscapeChar = 1'b0;
   localparam logic [CsrAddrW-1:0] CsrEndChar    = 1'b1;

   // Request kinds
   typedef enum logic [ActionW-1:0] {
      ACT_RX    = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   // Per-beat status from the parser/FIFO control
   typedef struct packed {
      logic               read_valid;
      logic [FillW-1:0]   fill_level;
      logic [FramesW-1:0] frames_done;
      logic               frame_end;
      logic               overflow;
   } status_type;

endpackage

[src/bsd_ram.sv]
`timescale 1ns / 1ps

module bsd_ram #(
   parameter int Depth = bsd_pkg::DefaultFifoDepth
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(Depth)-1:0]    wr_addr,
   input  logic [bsd_pkg::ByteW-1:0]   wr_data,
   input  logic                        rd_en,
   input  logic [$clog2(Depth)-1:0]    rd_addr,
   output logic [bsd_pkg::ByteW-1:0]   rd_data
);

   logic [bsd_pkg::ByteW-1:0] mem [Depth];
   logic [bsd_pkg::ByteW-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bsd_core.sv]
`timescale 1ns / 1ps

module bsd_core #(
   parameter int FifoDepth = bsd_pkg::DefaultFifoDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  bsd_pkg::action_type           action,
   input  logic [bsd_pkg::ByteW-1:0]     rx_byte,
   input  logic [bsd_pkg::ByteW-1:0]     escape_char,
   input  logic [bsd_pkg::ByteW-1:0]     end_char,
   output bsd_pkg::status_type           status,
   output logic                          mem_wr_en,
   output logic [$clog2(FifoDepth)-1:0]  mem_wr_addr,
   output logic                          mem_rd_en,
   output logic [$clog2(FifoDepth)-1:0]  mem_rd_addr
);

   localparam int AddrW = $clog2(FifoDepth);
   localparam int CntW  = $clog2(FifoDepth + 1);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_FRAME = 2'd1,
      ST_ESC   = 2'd2
   } parse_state_type;

   parse_state_type                state_ff, state_in;
   logic [AddrW-1:0]               wr_idx_ff, wr_idx_in;
   logic [AddrW-1:0]               rd_idx_ff, rd_idx_in;
   logic [CntW-1:0]                fill_ff, fill_in;
   logic [bsd_pkg::FramesW-1:0]    frames_ff, frames_in;
   logic                           full, empty;
   logic                           push_req, pushed, popped;
   logic                           frame_end, overflow;

   assign full  = (fill_ff == CntW'(FifoDepth));
   assign empty = (fill_ff == '0);

   // Parser and FIFO bookkeeping for one beat
   always_comb begin
      state_in  = state_ff;
      frames_in = frames_ff;
      push_req  = 1'b0;
      popped    = 1'b0;
      frame_end = 1'b0;
      case (action)
         bsd_pkg::ACT_RX: begin
            unique case (state_ff)
               ST_IDLE: begin
                  if (rx_byte == escape_char) begin
                     state_in = ST_FRAME;
                  end
               end
               ST_FRAME: begin
                  if (rx_byte == end_char) begin
                     frames_in = frames_ff + bsd_pkg::FramesW'(1);
                     frame_end = 1'b1;
                     state_in  = ST_IDLE;
                  end else if (rx_byte == escape_char) begin
                     state_in = ST_ESC;
                  end else begin
                     push_req = 1'b1;
                  end
               end
               ST_ESC: begin
                  push_req = 1'b1;
                  state_in = ST_FRAME;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         bsd_pkg::ACT_READ: begin
            popped = !empty;
         end
         bsd_pkg::ACT_CLEAR: begin
            state_in  = ST_IDLE;
            frames_in = '0;
         end
         default: begin
         end
      endcase

      pushed   = push_req && !full;
      overflow = push_req && full;

      // Index and fill updates; clear overrides
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      fill_in   = fill_ff;
      if (pushed) begin
         wr_idx_in = (wr_idx_ff == AddrW'(FifoDepth - 1)) ? '0 : wr_idx_ff + AddrW'(1);
         fill_in   = fill_ff + CntW'(1);
      end
      if (popped) begin
         rd_idx_in = (rd_idx_ff == AddrW'(FifoDepth - 1)) ? '0 : rd_idx_ff + AddrW'(1);
         fill_in   = fill_ff - CntW'(1);
      end
      if (action == bsd_pkg::ACT_CLEAR) begin
         wr_idx_in = '0;
         rd_idx_in = '0;
         fill_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         fill_ff   <= '0;
         frames_ff <= '0;
      end else if (step) begin
         state_ff  <= state_in;
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         fill_ff   <= fill_in;
         frames_ff <= frames_in;
      end
   end

   // Memory access for this beat
   assign mem_wr_en   = step && pushed;
   assign mem_wr_addr = wr_idx_ff;
   assign mem_rd_en   = step && popped;
   assign mem_rd_addr = rd_idx_ff;

   // Status reflects the state after this beat
   assign status.read_valid  = popped;
   assign status.fill_level  = bsd_pkg::FillW'(fill_in);
   assign status.frames_done = frames_in;
   assign status.frame_end   = frame_end;
   assign status.overflow    = overflow;

endmodule

[src/byte_stuffing_deframer_fifo.sv]
`timescale 1ns / 1ps
// Receive-side byte-stuffing deframer with a byte FIFO.
// req channel: one beat per request. req_tuser carries the request kind
// (received byte, read one byte, clear, no-op); req_tdata carries the line
// byte. Framed payload bytes are unstuffed and buffered in a FIFO_DEPTH-byte
// RAM; reads pop the oldest byte.
// rsp channel: exactly one beat per request, in order. rsp_tlast flags the
// byte that closed a frame, rsp_tuser flags a read that returned data, and
// rsp_tdata carries read data, fill level, frame count and overflow.
// Stages: a result passes the input register, then the result register with
// the RAM read port. Throughput is one beat per cycle while rsp_tready
// holds; the parser/FIFO update is the only loop.
// csr port: writes escape/start and end markers; write only while idle.
// Reset: parser idle, FIFO empty, frame count zero, markers 'A' and 'Z'.
// RAM contents are not cleared. When rsp_tready is low the result register
// holds, one more request is held in the input register, then req_tready
// drops until the receiver takes the result.
`include "byte_stuffing_deframer_fifo_assert.svh"

module byte_stuffing_deframer_fifo #(
   parameter int FIFO_DEPTH = bsd_pkg::DefaultFifoDepth
) (
   input  logic                           clock,
   input  logic                           reset,
   // request: tdata = rx_byte[7:0]; tuser = action[1:0]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,
   input  logic [1:0]                     req_tuser,
   // result: tdata = read_data[7:0], fill_level[18:8], frames_done[34:19],
   //         overflow[35], zero[39:36]; tuser = read_valid
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [39:0]                    rsp_tdata,
   output logic                           rsp_tuser,
   output logic                           rsp_tlast,
   // register writes
   input  logic                           csr_we,
   input  logic [bsd_pkg::CsrAddrW-1:0]   csr_addr,
   input  logic [bsd_pkg::ByteW-1:0]      csr_wdata
);

   localparam int AddrW = $clog2(FIFO_DEPTH);

   logic [bsd_pkg::ByteW-1:0]  escape_char_ff;
   logic [bsd_pkg::ByteW-1:0]  end_char_ff;

   logic                       a_valid_ff;
   bsd_pkg::action_type        a_action_ff;
   logic [bsd_pkg::ByteW-1:0]  a_byte_ff;

   logic                       b_valid_ff;
   bsd_pkg::status_type        b_status_ff;

   logic                       advance;
   bsd_pkg::status_type        status;
   logic                       mem_wr_en, mem_rd_en;
   logic [AddrW-1:0]           mem_wr_addr, mem_rd_addr;
   logic [bsd_pkg::ByteW-1:0]  mem_rd_data;
   logic [bsd_pkg::ByteW-1:0]  read_data;

   // Marker registers
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_char_ff <= bsd_pkg::EscapeCharReset;
         end_char_ff    <= bsd_pkg::EndCharReset;
      end else if (csr_we) begin
         unique case (csr_addr)
            bsd_pkg::CsrEscapeChar: escape_char_ff <= csr_wdata;
            bsd_pkg::CsrEndChar:    end_char_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Handshake: stage A moves into the result register when it is free
   assign advance    = a_valid_ff && (!b_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_tready) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         a_action_ff <= bsd_pkg::action_type'(req_tuser);
         a_byte_ff   <= req_tdata;
      end
   end

   bsd_core #(
      .FifoDepth (FIFO_DEPTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .action      (a_action_ff),
      .rx_byte     (a_byte_ff),
      .escape_char (escape_char_ff),
      .end_char    (end_char_ff),
      .status      (status),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr)
   );

   bsd_ram #(
      .Depth (FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (a_byte_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Result register; RAM read data lands alongside it
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (!b_valid_ff || rsp_tready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_status_ff <= status;
      end
   end

   // Only a successful read shows RAM data
   assign read_data = b_status_ff.read_valid ? mem_rd_data : '0;

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        b_status_ff.overflow,
                        b_status_ff.frames_done,
                        b_status_ff.fill_level,
                        read_data};
   assign rsp_tuser  = b_status_ff.read_valid;
   assign rsp_tlast  = b_status_ff.frame_end;

   // Checks
   `BSD_ASSERT_NOW(a_frame_end_alone, clock, reset, b_valid_ff && b_status_ff.frame_end, !b_status_ff.read_valid && !b_status_ff.overflow, "frame end together with read or overflow")
   `BSD_ASSERT_NOW(a_read_data_zero, clock, reset, b_valid_ff && !b_status_ff.read_valid, read_data == '0, "read data nonzero without a valid read")
   `BSD_ASSERT_NEXT(a_clear_empties, clock, reset, advance && (a_action_ff == bsd_pkg::ACT_CLEAR), b_valid_ff && (b_status_ff.fill_level == '0) && (b_status_ff.frames_done == '0), "clear left data or frames")

endmodule

[sim/tb_byte_stuffing_deframer_fifo.sv]
`timescale 1ns / 1ps

module tb_byte_stuffing_deframer_fifo;
   import bsd_pkg::*;

   localparam int FifoDepth  = DefaultFifoDepth;
   localparam int DrainLimit = 50000;

   // parser phases of the deframer
   typedef enum logic [1:0] {
      PS_IDLE,
      PS_FRAME,
      PS_ESCAPED
   } parse_phase_type;

   // one result beat, unpacked from the rsp channel
   typedef struct packed {
      logic [ByteW-1:0]   read_data;
      logic               read_valid;
      logic [FillW-1:0]   fill_level;
      logic [FramesW-1:0] frames_done;
      logic               frame_end;
      logic               overflow;
   } deframe_result_type;

   // directed stimulus row; want is used only when typed is set
   typedef struct packed {
      action_type         act;
      logic [ByteW-1:0]   rx_byte;
      logic               typed;
      deframe_result_type want;
   } stim_row_type;

   localparam deframe_result_type QuietResult = '0;

   // reset markers are start/escape 'A' and end 'Z'
   localparam stim_row_type DirectedRows [0:21] = '{
      '{ACT_NOP,   8'h00,           1'b1, QuietResult},
      '{ACT_READ,  8'h00,           1'b1, QuietResult},
      '{ACT_RX,    EndCharReset,    1'b1, QuietResult},
      '{ACT_RX,    8'h00,           1'b1, QuietResult},
      '{ACT_RX,    EscapeCharReset, 1'b1, QuietResult},
      '{ACT_RX,    8'h00,           1'b0, QuietResult},
      '{ACT_RX,    8'hFF,           1'b0, QuietResult},
      '{ACT_RX,    EscapeCharReset, 1'b0, QuietResult},
      '{ACT_RX,    EndCharReset,    1'b0, QuietResult},
      '{ACT_RX,    EscapeCharReset, 1'b0, QuietResult},
      '{ACT_RX,    EscapeCharReset, 1'b0, QuietResult},
      '{ACT_RX,    EndCharReset,    1'b1, '{8'h00, 1'b0, 11'd4, 16'd1, 1'b1, 1'b0}},
      '{ACT_READ,  8'h00,           1'b1, '{8'h00, 1'b1, 11'd3, 16'd1, 1'b0, 1'b0}},
      '{ACT_READ,  8'hA5,           1'b1, '{8'hFF, 1'b1, 11'd2, 16'd1, 1'b0, 1'b0}},
      '{ACT_NOP,   8'hFF,           1'b0, QuietResult},
      '{ACT_RX,    EscapeCharReset, 1'b0, QuietResult},
      '{ACT_RX,    EndCharReset,    1'b0, QuietResult},
      '{ACT_RX,    EscapeCharReset, 1'b0, QuietResult},
      '{ACT_RX,    8'h37,           1'b0, QuietResult},
      '{ACT_CLEAR, 8'h5A,           1'b1, QuietResult},
      '{ACT_RX,    8'h37,           1'b1, QuietResult},
      '{ACT_READ,  8'h00,           1'b1, QuietResult}
   };

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata  = '0;
   logic [1:0]          req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [39:0]         rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;
   logic                csr_we     = 1'b0;
   logic [CsrAddrW-1:0] csr_addr   = '0;
   logic [ByteW-1:0]    csr_wdata  = '0;

   bit calm        = 1'b0;
   int error_count = 0;
   int sent_count  = 0;
   deframe_result_type pending_results[$];

   // shadow state of the deframer
   logic [ByteW-1:0]   mdl_escape = EscapeCharReset;
   logic [ByteW-1:0]   mdl_end    = EndCharReset;
   parse_phase_type    mdl_phase  = PS_IDLE;
   int                 mdl_wr     = 0;
   int                 mdl_rd     = 0;
   int                 mdl_fill   = 0;
   logic [FramesW-1:0] mdl_frames = '0;
   logic [ByteW-1:0]   mdl_bytes [FifoDepth];

   byte_stuffing_deframer_fifo uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop
   initial begin
      #3_000_000;
      $display("tb_byte_stuffing_deframer_fifo failed");
      $finish;
   end

   task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
      error_count++;
      $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
   endtask

   // store a payload byte; false when the buffer is full and the byte is dropped
   function automatic bit push_byte(logic [ByteW-1:0] b);
      if (mdl_fill >= FifoDepth)
         return 1'b0;
      mdl_bytes[mdl_wr] = b;
      mdl_wr = (mdl_wr + 1) % FifoDepth;
      mdl_fill++;
      return 1'b1;
   endfunction

   // advance the shadow deframer by one request and return its status beat
   function automatic deframe_result_type predict_deframe(action_type act,
                                                          logic [ByteW-1:0] b);
      deframe_result_type r;
      r = '0;
      case (act)
         ACT_RX: begin
            case (mdl_phase)
               PS_IDLE: begin
                  if (b == mdl_escape)
                     mdl_phase = PS_FRAME;
               end
               PS_FRAME: begin
                  // end marker wins when both markers are equal
                  if (b == mdl_end) begin
                     mdl_frames  = mdl_frames + 1'b1;
                     r.frame_end = 1'b1;
                     mdl_phase   = PS_IDLE;
                  end else if (b == mdl_escape) begin
                     mdl_phase = PS_ESCAPED;
                  end else begin
                     r.overflow = !push_byte(b);
                  end
               end
               default: begin
                  // escaped byte goes in literally, markers included
                  r.overflow = !push_byte(b);
                  mdl_phase  = PS_FRAME;
               end
            endcase
         end
         ACT_READ: begin
            if (mdl_fill > 0) begin
               r.read_data  = mdl_bytes[mdl_rd];
               r.read_valid = 1'b1;
               mdl_rd = (mdl_rd + 1) % FifoDepth;
               mdl_fill--;
            end
         end
         ACT_CLEAR: begin
            mdl_phase  = PS_IDLE;
            mdl_wr     = 0;
            mdl_rd     = 0;
            mdl_fill   = 0;
            mdl_frames = '0;
         end
         default: ;
      endcase
      r.fill_level  = FillW'(mdl_fill);
      r.frames_done = mdl_frames;
      return r;
   endfunction

   // drive one request beat, with random gaps ahead of it
   task automatic send_req(action_type act, logic [ByteW-1:0] b, logic typed = 1'b0,
                           deframe_result_type want = '0);
      deframe_result_type got;
      while (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      got = predict_deframe(act, b);
      pending_results.push_back(typed ? want : got);
      sent_count++;
   endtask

   // payload byte, stuffed when it collides with a marker (and now and then anyway)
   task automatic send_payload(logic [ByteW-1:0] b);
      if (b == mdl_escape || b == mdl_end || $urandom_range(99) < 5)
         send_req(ACT_RX, mdl_escape);
      send_req(ACT_RX, b);
   endtask

   // let every outstanding beat come back, then allow the pipeline to settle
   task automatic wait_results_done();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         report_mismatch("results outstanding", 0, pending_results.size());
         pending_results.delete();
      end
      repeat (6) @(posedge clock);
   endtask

   // write both marker registers; only called with the block idle
   task automatic set_markers(logic [ByteW-1:0] esc, logic [ByteW-1:0] fin);
      csr_we    <= 1'b1;
      csr_addr  <= CsrEscapeChar;
      csr_wdata <= esc;
      @(posedge clock);
      csr_addr  <= CsrEndChar;
      csr_wdata <= fin;
      @(posedge clock);
      csr_we     <= 1'b0;
      mdl_escape = esc;
      mdl_end    = fin;
      @(posedge clock);
   endtask

   // mostly framed traffic with random payload, plus reads, noise, broken frames
   task automatic send_random_traffic(int n);
      int stop_at;
      int pick;
      stop_at = sent_count + n;
      while (sent_count < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            send_req(ACT_RX, mdl_escape);
            repeat ($urandom_range(12)) send_payload(8'($urandom));
            // one frame in ten is left open
            if ($urandom_range(9) != 0)
               send_req(ACT_RX, mdl_end);
         end else if (pick < 88) begin
            repeat ($urandom_range(6, 1)) send_req(ACT_READ, 8'($urandom));
         end else if (pick < 97) begin
            send_req(action_type'($urandom_range(3)), 8'($urandom));
         end else begin
            send_req(ACT_CLEAR, 8'($urandom));
         end
      end
   endtask

   // one long frame that fills the buffer, then runs along the full mark
   task automatic flood_fifo();
      send_req(ACT_RX, mdl_escape);
      calm = 1'b1;
      repeat (FifoDepth / 2) send_payload(8'($urandom));
      calm = 1'b0;
      while (mdl_fill < FifoDepth)
         send_payload(8'($urandom));
      repeat (100) begin
         if ($urandom_range(99) < 40)
            send_req(ACT_READ, 8'($urandom));
         else
            send_payload(8'($urandom));
      end
      send_req(ACT_RX, mdl_end);
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 31);
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin : result_check
      deframe_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result beat", 0, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[7:0] !== want.read_data)
               report_mismatch("read_data", want.read_data, rsp_tdata[7:0]);
            if (rsp_tuser !== want.read_valid)
               report_mismatch("read_valid", want.read_valid, rsp_tuser);
            if (rsp_tdata[18:8] !== want.fill_level)
               report_mismatch("fill_level", want.fill_level, rsp_tdata[18:8]);
            if (rsp_tdata[34:19] !== want.frames_done)
               report_mismatch("frames_done", want.frames_done, rsp_tdata[34:19]);
            if (rsp_tlast !== want.frame_end)
               report_mismatch("frame_end", want.frame_end, rsp_tlast);
            if (rsp_tdata[35] !== want.overflow)
               report_mismatch("overflow", want.overflow, rsp_tdata[35]);
            if (rsp_tdata[39:36] !== 4'h0)
               report_mismatch("tdata padding", 0, rsp_tdata[39:36]);
         end
      end
   end

   initial begin : stimulus
      logic [ByteW-1:0] marker;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at the reset markers
      foreach (DirectedRows[i])
         send_req(DirectedRows[i].act, DirectedRows[i].rx_byte, DirectedRows[i].typed,
                  DirectedRows[i].want);
      wait_results_done();

      // extreme marker values
      set_markers(8'h00, 8'hFF);
      send_random_traffic(100);
      wait_results_done();

      // overflow at the full mark, markers swapped to the other extremes
      set_markers(8'hFF, 8'h00);
      flood_fifo();
      send_req(ACT_CLEAR, 8'($urandom));
      wait_results_done();

      // same byte for both markers
      marker = 8'($urandom);
      set_markers(marker, marker);
      send_random_traffic(80);
      wait_results_done();

      set_markers(8'($urandom), 8'($urandom));
      send_random_traffic(80);
      wait_results_done();

      if (error_count == 0)
         $display("tb_byte_stuffing_deframer_fifo passed");
      else
         $display("tb_byte_stuffing_deframer_fifo failed");
      $finish;
   end

endmodule
